### hw/rtl/glsf_pkg.sv
// Shared types and constants for the group label size filter and relabeller.
`timescale 1ns / 1ps
package glsf_pkg;

  localparam int MAX_POINTS = 16384;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int PL_W       = PT_AW + 1;
  localparam int MAX_GROUPS = 1024;
  localparam int GRP_AW     = $clog2(MAX_GROUPS);
  localparam int GRP_CW     = GRP_AW + 1;
  localparam int LABEL_W    = 32;
  localparam int CNT_W      = 15;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 96;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic CFG_MERGE     = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_LD_A, ST_LD_B, ST_SCAN, ST_SCAN_END,
    ST_MAP, ST_MAP_END, ST_EMIT_S, ST_Q_A, ST_Q_B, ST_EMIT_Q
  } state_t;

  typedef struct packed {
    logic capture;
    logic run_clear;
    logic clr_wr;
    logic ld_a;
    logic ld_b;
    logic renum_init;
    logic scan_rd;
    logic sweep_clr;
    logic map_rd;
    logic q_a;
    logic q_b;
    logic emit_q;
    logic emit_s;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic       run_end;
    logic       sweep_last;
    logic       bad_idx;
    logic       out_free;
  } status_t;

endpackage

### hw/rtl/glsf_ctrl.sv
// Controller state machine: sequences loads, renumbering sweeps, queries and clears.
`timescale 1ns / 1ps
module glsf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  glsf_pkg::status_t sts,
  output glsf_pkg::cmd_t    cmd
);
  import glsf_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (sts.in_op)
            OP_LOAD:  state_nxt = ST_LD_A;
            OP_QUERY: state_nxt = ST_Q_A;
            OP_CLEAR: begin
              cmd.run_clear = 1'b1;
              state_nxt     = ST_CLR;
            end
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LD_A: begin
        cmd.ld_a  = 1'b1;
        state_nxt = ST_LD_B;
      end
      ST_LD_B: begin
        cmd.ld_b = 1'b1;
        if (sts.run_end) begin
          cmd.renum_init = 1'b1;
          state_nxt      = ST_SCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.sweep_last) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        cmd.sweep_clr = 1'b1;
        state_nxt     = ST_MAP;
      end
      ST_MAP: begin
        cmd.map_rd = 1'b1;
        if (sts.sweep_last) state_nxt = ST_MAP_END;
      end
      ST_MAP_END: begin
        state_nxt = ST_EMIT_S;
      end
      ST_EMIT_S: begin
        if (sts.out_free) begin
          cmd.emit_s = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_Q_A: begin
        cmd.q_a   = 1'b1;
        state_nxt = sts.bad_idx ? ST_EMIT_Q : ST_Q_B;
      end
      ST_Q_B: begin
        cmd.q_b   = 1'b1;
        state_nxt = ST_EMIT_Q;
      end
      ST_EMIT_Q: begin
        if (sts.out_free) begin
          cmd.emit_q = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/glsf_dp.sv
// Datapath: label store, histogram, label map, run registers and result register.
`timescale 1ns / 1ps
module glsf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  glsf_pkg::cmd_t                      cmd,
  output glsf_pkg::status_t                   sts,
  input  logic [glsf_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [1:0]                          in_tuser,
  input  logic                                in_tlast,
  input  logic                                cfg_valid,
  input  logic                                cfg_index,
  input  logic [glsf_pkg::CNT_W-1:0]          cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [glsf_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tuser
);
  import glsf_pkg::*;

  logic [LABEL_W-1:0] pt_mem  [MAX_POINTS];
  logic [CNT_W-1:0]   cnt_mem [MAX_GROUPS];
  logic [GRP_AW-1:0]  map_mem [MAX_GROUPS];

  // captured item
  logic [LABEL_W-1:0] lbl_r;
  logic               set_end_r, run_end_r;
  logic [PT_AW-1:0]   idx_r;

  logic               merge_r;
  logic [CNT_W-1:0]   thr_r;

  logic [LABEL_W-1:0] max_label_r, set_offset_r;
  logic [PL_W-1:0]    pl_r;
  logic               set_starting_r;

  logic [GRP_AW-1:0]  g_idx_r;
  logic               ld_cnt_r;

  logic [GRP_AW-1:0]  sweep_r, a_r;
  logic               scan_v_r, map_v_r;
  logic [GRP_CW-1:0]  span_r, next_r;

  logic [LABEL_W-1:0] pt_q_r;
  logic [CNT_W-1:0]   cnt_q_r;
  logic [GRP_AW-1:0]  map_q_r;
  logic               bad_r;

  logic               out_valid_r;
  logic               out_kind_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [LABEL_W-1:0] off_eff, g;
  logic               full;
  logic [GRP_AW-1:0]  cnt_raddr;
  logic               cnt_ren;
  logic               map_hit;
  logic               q_valid, q_kept;
  logic [CNT_W-1:0]   q_size;
  logic [LABEL_W-1:0] q_new;

  always_comb begin
    off_eff = set_offset_r;
    if (set_starting_r) begin
      off_eff = (max_label_r == '0) ? '0 : max_label_r + 1'b1;
    end
    g       = merge_r ? lbl_r : lbl_r + off_eff;
    full    = (pl_r == PL_W'(MAX_POINTS));
    map_hit = ({1'b0, a_r} < span_r) && (cnt_q_r >= thr_r);
    q_valid = (pt_q_r[LABEL_W-1:GRP_AW] == '0);
    q_size  = q_valid ? cnt_q_r : '0;
    q_kept  = q_valid && (q_size >= thr_r);
    q_new   = q_kept ? {{(LABEL_W-GRP_AW){1'b0}}, map_q_r} : pt_q_r;
    cnt_ren = cmd.ld_a | cmd.scan_rd | cmd.map_rd | cmd.q_b;
    if (cmd.ld_a) begin
      cnt_raddr = g[GRP_AW-1:0];
    end else if (cmd.q_b) begin
      cnt_raddr = pt_q_r[GRP_AW-1:0];
    end else begin
      cnt_raddr = sweep_r;
    end
  end

  assign sts.in_op      = in_tuser;
  assign sts.run_end    = run_end_r;
  assign sts.sweep_last = (sweep_r == {GRP_AW{1'b1}});
  assign sts.bad_idx    = ({1'b0, idx_r} >= pl_r);
  assign sts.out_free   = !out_valid_r || out_tready;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.ld_a && !full) pt_mem[pl_r[PT_AW-1:0]] <= g;
    if (cmd.q_a) pt_q_r <= pt_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      cnt_mem[sweep_r] <= '0;
    end else if (cmd.ld_b && ld_cnt_r && cnt_q_r != COUNT_MAX) begin
      cnt_mem[g_idx_r] <= cnt_q_r + 1'b1;
    end
    if (cnt_ren) cnt_q_r <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (map_v_r) map_mem[a_r] <= map_hit ? next_r[GRP_AW-1:0] : '0;
    if (cmd.q_b) map_q_r <= map_mem[pt_q_r[GRP_AW-1:0]];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lbl_r     <= in_tdata[LABEL_W-1:0];
      set_end_r <= in_tdata[LABEL_W];
      idx_r     <= in_tdata[LABEL_W+PT_AW:LABEL_W+1];
      run_end_r <= in_tlast;
    end
    if (cmd.ld_a) g_idx_r <= g[GRP_AW-1:0];
    if (cmd.scan_rd || cmd.map_rd) a_r <= sweep_r;
    if (cmd.q_a) bad_r <= sts.bad_idx;
    if (cmd.emit_s) begin
      out_kind_r <= 1'b1;
      out_data_r <= {4'b0, 1'b0, next_r, {CNT_W{1'b0}}, 1'b0, {(2*LABEL_W){1'b0}}};
    end else if (cmd.emit_q) begin
      out_kind_r <= 1'b0;
      if (bad_r) begin
        out_data_r <= {4'b0, 1'b1, {(OUT_DATA_W-5){1'b0}}};
      end else begin
        out_data_r <= {4'b0, 1'b0, {GRP_CW{1'b0}}, q_size, q_kept, pt_q_r, q_new};
      end
    end
  end

  // control and run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merge_r        <= 1'b0;
      thr_r          <= '0;
      max_label_r    <= '0;
      set_offset_r   <= '0;
      pl_r           <= '0;
      set_starting_r <= 1'b1;
      ld_cnt_r       <= 1'b0;
      sweep_r        <= '0;
      scan_v_r       <= 1'b0;
      map_v_r        <= 1'b0;
      span_r         <= '0;
      next_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MERGE:     merge_r <= cfg_data[0];
          CFG_THRESHOLD: thr_r   <= cfg_data;
          default:       merge_r <= merge_r;
        endcase
      end
      scan_v_r <= cmd.scan_rd;
      map_v_r  <= cmd.map_rd;
      if (cmd.run_clear) begin
        max_label_r    <= '0;
        set_offset_r   <= '0;
        pl_r           <= '0;
        set_starting_r <= 1'b1;
      end
      if (cmd.ld_a) begin
        if (set_starting_r) set_offset_r <= off_eff;
        set_starting_r <= set_end_r | run_end_r;
        ld_cnt_r       <= !full && (g[LABEL_W-1:GRP_AW] == '0);
        if (!full) begin
          pl_r <= pl_r + 1'b1;
          if (g > max_label_r) max_label_r <= g;
        end
      end
      if (cmd.run_clear || cmd.sweep_clr || cmd.renum_init) begin
        sweep_r <= '0;
      end else if (cmd.clr_wr || cmd.scan_rd || cmd.map_rd) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (cmd.renum_init) begin
        span_r <= '0;
        next_r <= '0;
      end
      if (scan_v_r && cnt_q_r != '0) span_r <= {1'b0, a_r} + 1'b1;
      if (map_v_r && map_hit) next_r <= next_r + 1'b1;
      if (cmd.emit_s) max_label_r <= {{(LABEL_W-GRP_CW){1'b0}}, next_r} - 1'b1;
      if (cmd.emit_s || cmd.emit_q) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  a_pl_range: assert property (@(posedge clk) disable iff (!rst_n)
    pl_r <= PL_W'(MAX_POINTS)) else $error("point count beyond store depth");
  a_next_span: assert property (@(posedge clk) disable iff (!rst_n)
    next_r <= span_r) else $error("more kept groups than scanned span");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_q || cmd.emit_s) |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");
  a_sweep_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(scan_v_r && map_v_r)) else $error("scan and map passes overlap");

endmodule

### hw/rtl/group_label_size_filter_relabel.sv
// Top level of the group label size filter and relabeller.
`timescale 1ns / 1ps
// Channel  Dir  Handshake               Payload
// in_      in   in_tvalid/in_tready     tdata: group_label, set_end, point_index; tuser: op;
//                                       tlast: run_end
// out_     out  out_tvalid/out_tready   tdata: new_label .. bad_index; tuser: kind
// cfg_     in   cfg_valid/cfg_ready     cfg_index (0 merge_groups, 1 size_threshold), cfg_data
//
// One transaction at a time. A load writes the label store, then updates the histogram;
// a load with run end adds two sweeps over all 1024 histogram entries (span search, then map write).
// A query chains reads of the label store, then the histogram and map; the second step is
// skipped if the index is not loaded. A clear sweeps the histogram to zero.
// After reset a clearing pass empties the histogram; in_tready stays low.
// The result register lets the next input transaction in while a result is stalled.
module group_label_size_filter_relabel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // group_label[31:0], set_end[32], point_index[46:33]
  input  logic [1:0]  in_tuser,   // op[1:0]
  input  logic        in_tlast,   // run_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // new_label[31:0], stored_label[63:32], kept[64],
                                  // group_size[79:65], kept_groups[90:80], bad_index[91]
  output logic        out_tuser,  // kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data
);
  import glsf_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // registers are always writable; writes must come only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  glsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  glsf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
